// ===== hdl/mte_pkg.sv =====
// Shared types, symbol codes and the Morse code table for the Morse text encoder.
// No dependencies; mte_builder, mte_serializer and morse_text_encoder refer to this package.
`timescale 1ns / 1ps

package mte_pkg;

  // Output symbol codes.
  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SPACE = 2'd2;
  localparam logic [1:0] SYM_SLASH = 2'd3;

  // Most symbols one text byte can cause: a separator and a six-symbol code.
  localparam int MaxSyms = 7;
  localparam int CntW    = 3;

  // Character codes used by the case folding and whitespace detection.
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // One Morse code: len symbols, first symbol in pat[len-1], a dash is a one.
  // A length of zero marks a character with no code.
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] pat;
  } code_t;

  // Symbols queued for one text byte, element 0 goes out first.
  typedef struct packed {
    logic [MaxSyms-1:0][1:0] syms;
    logic [CntW-1:0]         count;
  } seq_t;

  // Encoder state carried from one transaction to the next.
  typedef struct packed {
    logic after_word_break;
    logic anything_emitted;
  } flags_t;

  // Morse code table, indexed by an upper-case character.
  function automatic code_t char_code(input logic [7:0] c);
    code_t r;
    r = '{3'd0, 6'b000000};
    case (c)
      "A": r = '{3'd2, 6'b000001};
      "B": r = '{3'd4, 6'b001000};
      "C": r = '{3'd4, 6'b001010};
      "D": r = '{3'd3, 6'b000100};
      "E": r = '{3'd1, 6'b000000};
      "F": r = '{3'd4, 6'b000010};
      "G": r = '{3'd3, 6'b000110};
      "H": r = '{3'd4, 6'b000000};
      "I": r = '{3'd2, 6'b000000};
      "J": r = '{3'd4, 6'b000111};
      "K": r = '{3'd3, 6'b000101};
      "L": r = '{3'd4, 6'b000100};
      "M": r = '{3'd2, 6'b000011};
      "N": r = '{3'd2, 6'b000010};
      "O": r = '{3'd3, 6'b000111};
      "P": r = '{3'd4, 6'b000110};
      "Q": r = '{3'd4, 6'b001101};
      "R": r = '{3'd3, 6'b000010};
      "S": r = '{3'd3, 6'b000000};
      "T": r = '{3'd1, 6'b000001};
      "U": r = '{3'd3, 6'b000001};
      "V": r = '{3'd4, 6'b000001};
      "W": r = '{3'd3, 6'b000011};
      "X": r = '{3'd4, 6'b001001};
      "Y": r = '{3'd4, 6'b001011};
      "Z": r = '{3'd4, 6'b001100};
      "0": r = '{3'd5, 6'b011111};
      "1": r = '{3'd5, 6'b001111};
      "2": r = '{3'd5, 6'b000111};
      "3": r = '{3'd5, 6'b000011};
      "4": r = '{3'd5, 6'b000001};
      "5": r = '{3'd5, 6'b000000};
      "6": r = '{3'd5, 6'b010000};
      "7": r = '{3'd5, 6'b011000};
      "8": r = '{3'd5, 6'b011100};
      "9": r = '{3'd5, 6'b011110};
      ".": r = '{3'd6, 6'b010101};
      ",": r = '{3'd6, 6'b110011};
      "?": r = '{3'd6, 6'b001100};
      "!": r = '{3'd6, 6'b101011};
      "/": r = '{3'd5, 6'b010010};
      "(": r = '{3'd5, 6'b010110};
      ")": r = '{3'd6, 6'b101101};
      "&": r = '{3'd5, 6'b001000};
      ":": r = '{3'd6, 6'b111000};
      ";": r = '{3'd6, 6'b101010};
      "=": r = '{3'd5, 6'b010001};
      "+": r = '{3'd5, 6'b001010};
      "-": r = '{3'd6, 6'b100001};
      "_": r = '{3'd6, 6'b001101};
      8'h22: r = '{3'd6, 6'b010010};
      "@": r = '{3'd6, 6'b011010};
      default: r = '{3'd0, 6'b000000};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/mte_in_if.sv =====
// Input channel of the Morse text encoder: one text byte per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface mte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       message_start;

  modport source (output valid, output text_byte, output message_start, input ready);
  modport sink (input valid, input text_byte, input message_start, output ready);
endinterface

// ===== hdl/mte_out_if.sv =====
// Output channel of the Morse text encoder: one Morse symbol per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface mte_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       last_of_run;

  modport source (output valid, output symbol, output last_of_run, input ready);
  modport sink (input valid, input symbol, input last_of_run, output ready);
endinterface

// ===== hdl/mte_builder.sv =====
// Combinational symbol sequence builder: folds case, looks up the Morse code
// and works out separators and word breaks. Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_builder (
  input  logic [7:0]      text_byte,
  input  logic            message_start,
  input  mte_pkg::flags_t flags,
  output mte_pkg::seq_t   seq,
  output mte_pkg::flags_t flags_next
);

  logic            wb;
  logic            ae;
  logic            due;
  logic            white;
  logic [7:0]      c;
  mte_pkg::code_t  code;

  // A new message starts with both flags cleared.
  assign wb  = message_start ? 1'b0 : flags.after_word_break;
  assign ae  = message_start ? 1'b0 : flags.anything_emitted;
  assign due = !wb && ae;

  // Fold lower-case letters and classify the byte.
  assign c = (text_byte >= mte_pkg::CHR_LOWER_A && text_byte <= mte_pkg::CHR_LOWER_Z) ?
             text_byte - mte_pkg::CASE_OFFSET : text_byte;
  assign white = (c == mte_pkg::CHR_SPACE) ||
                 (c >= mte_pkg::CHR_TAB && c <= mte_pkg::CHR_CR);
  assign code = mte_pkg::char_code(c);

  // Lay out the symbols, a separator first when one is due.
  always_comb begin
    logic [2:0] pos;
    logic [2:0] idx;
    pos = '0;
    idx = '0;
    seq.syms   = '0;
    seq.count  = '0;
    flags_next = '{after_word_break: wb, anything_emitted: ae};
    if (white) begin
      if (due) begin
        seq.syms[0] = mte_pkg::SYM_SPACE;
        seq.syms[1] = mte_pkg::SYM_SLASH;
        seq.syms[2] = mte_pkg::SYM_SPACE;
        seq.count   = 3'd3;
        flags_next.after_word_break = 1'b1;
      end
    end else if (code.len != 3'd0) begin
      for (int i = 0; i < mte_pkg::MaxSyms; i++) begin
        pos = 3'(i) - {2'b00, due};
        idx = code.len - 3'd1 - pos;
        if (due && i == 0) begin
          seq.syms[i] = mte_pkg::SYM_SPACE;
        end else if (pos < code.len) begin
          seq.syms[i] = code.pat[idx] ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
        end
      end
      seq.count  = code.len + {2'b00, due};
      flags_next = '{after_word_break: 1'b0, anything_emitted: 1'b1};
    end
  end

endmodule

// ===== hdl/mte_serializer.sv =====
// Symbol serializer: holds the sequence for one text byte and hands it out
// one symbol per transaction. Depends on mte_pkg and mte_out_if.
`timescale 1ns / 1ps

module mte_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  mte_pkg::seq_t seq,
  output logic          ready,
  mte_out_if.source     symbol_out
);

  logic [mte_pkg::MaxSyms-1:0][1:0] syms;
  logic [mte_pkg::CntW-1:0]         cnt;
  logic                             take;

  assign take = symbol_out.valid && symbol_out.ready;

  // A new sequence may be loaded when the serializer is empty or once the last symbol held is leaving.
  assign ready = (cnt == '0) || (cnt == mte_pkg::CntW'(1) && symbol_out.ready);

  assign symbol_out.valid       = (cnt != '0);
  assign symbol_out.symbol      = syms[0];
  assign symbol_out.last_of_run = (cnt == mte_pkg::CntW'(1));

  // Symbol count; reset empties the serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= seq.count;
    end else if (take) begin
      cnt <= cnt - mte_pkg::CntW'(1);
    end
  end

  // Symbol shift register, element 0 is the head.
  always_ff @(posedge clk) begin
    if (load) begin
      syms <= seq.syms;
    end else if (take) begin
      syms <= {mte_pkg::SYM_DOT, syms[mte_pkg::MaxSyms-1:1]};
    end
  end

endmodule

// ===== hdl/morse_text_encoder.sv =====
// Morse text encoder: the first symbol of an accepted text byte is offered in the next cycle.
// A byte is accepted when the serializer is empty or in the cycle its last symbol leaves; the
// output hands out one symbol a cycle while it is ready, one to seven symbols per byte, and a
// byte with no symbols leaves the serializer empty, ready for the next byte.
// Synchronous reset clears the word-break and emitted flags and empties the serializer.
`timescale 1ns / 1ps

module morse_text_encoder (
  input  logic      clk,
  input  logic      rst,
  mte_in_if.sink    text_in,
  mte_out_if.source symbol_out
);

  mte_pkg::flags_t flags;
  mte_pkg::flags_t flags_next;
  mte_pkg::seq_t   seq;
  logic            ser_ready;
  logic            accept;

  assign text_in.ready = ser_ready;
  assign accept        = text_in.valid && ser_ready;

  mte_builder u_builder (
    .text_byte     (text_in.text_byte),
    .message_start (text_in.message_start),
    .flags         (flags),
    .seq           (seq),
    .flags_next    (flags_next)
  );

  mte_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .seq        (seq),
    .ready      (ser_ready),
    .symbol_out (symbol_out)
  );

  // Message state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (accept) begin
      flags <= flags_next;
    end
  end

endmodule
